FILE: hdl/msdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msdc_pkg;

  localparam int SampleBits   = 16;
  localparam int NumAxes      = 6;
  localparam int GyroFirst    = 3;
  localparam int AxisSelBits  = 3;
  localparam int SqBits       = 32;
  localparam int ThrBits      = 32;
  localparam int CountBits    = 16;
  localparam int RingBits     = 3 * SampleBits;
  localparam int RingDepthDef = 32;
  localparam int InDataBits   = 6 * SampleBits;
  localparam int OutFieldBits = CountBits + 1 + 3 * SampleBits;
  localparam int OutDataBits  = ((OutFieldBits + 7) / 8) * 8;
  localparam int CfgIdxBits   = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ACCEL_THR = 1'b0,
    CFG_GYRO_THR  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_SNAP   = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DRAIN,
    ST_JUDGE,
    ST_STATUS,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic                   load;
    logic                   mul_en;
    logic [AxisSelBits-1:0] mul_sel;
    logic                   judge;
    logic                   out_status;
    logic                   out_snap;
    logic                   snap_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic shot;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/motion_shot_detector_capture.sv
// Channel   Dir  Transaction
// s_axis    in   one raw sample: accel x/y/z, rate x/y/z in tdata, clear flag in tuser
// m_axis    out  status item, or one captured ring entry (tuser = kind, tlast = last)
// cfg       in   threshold write, index 0 accel, index 1 gyro; no handshake
//
// A status item is offered after its sample has had six squares through one shared
// 16x16 multiplier, one accumulate drain, one compare, one output load; then a new sample
// can be taken. A shot adds RING_DEPTH ring dump transactions first, one a cycle barring stalls.
// Reset clears thresholds to defaults, counter, write slot and ring valid bits;
// unwritten entries read as zero. Output stalls hold the sequencer; a new sample is
// taken while the last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module motion_shot_detector_capture #(
  parameter int RING_DEPTH = msdc_pkg::RingDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [msdc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [msdc_pkg::ThrBits-1:0]     cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  wire logic [msdc_pkg::InDataBits-1:0]  s_axis_tdata,
  // clear_pressed
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // shot_count, shot_seen, snap_rate_x, snap_rate_y, snap_rate_z, zero pad
  output logic [msdc_pkg::OutDataBits-1:0]      m_axis_tdata,
  // item_kind
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import msdc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msdc_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  msdc_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_data_i  (s_axis_tdata),
    .s_clear_i (s_axis_tuser),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_kind_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: hdl/msdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module msdc_ctrl #(
  parameter int RING_DEPTH = msdc_pkg::RingDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire msdc_pkg::sts_t sts_i,
  output msdc_pkg::cmd_t     cmd_o
);
  import msdc_pkg::*;

  localparam int SlotW = $clog2(RING_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RING_DEPTH - 1);
  localparam logic [AxisSelBits-1:0] LastAxis = AxisSelBits'(NumAxes - 1);

  state_e                 state_q, state_d;
  logic [AxisSelBits-1:0] step_q, step_d;
  logic [SlotW-1:0]       cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = step_q;
        if (step_q == LastAxis) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = ST_STATUS;
      end
      ST_STATUS: begin
        if (sts_i.out_free) begin
          cmd_o.out_status = 1'b1;
          cnt_d            = '0;
          state_d          = sts_i.shot ? ST_DUMP : ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.out_snap  = 1'b1;
          cmd_o.snap_last = (cnt_q == LastSlot);
          if (cnt_q == LastSlot) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/msdc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module msdc_datapath #(
  parameter int RING_DEPTH = msdc_pkg::RingDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [msdc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [msdc_pkg::ThrBits-1:0]     cfg_data_i,
  input  wire logic [msdc_pkg::InDataBits-1:0]  s_data_i,
  input  wire logic                             s_clear_i,
  input  wire msdc_pkg::cmd_t                   cmd_i,
  output msdc_pkg::sts_t                        sts_o,
  output logic                                  m_valid_o,
  input  wire logic                             m_ready_i,
  output logic [msdc_pkg::OutDataBits-1:0]      m_data_o,
  output logic                                  m_kind_o,
  output logic                                  m_last_o
);
  import msdc_pkg::*;

  localparam int SlotW = $clog2(RING_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RING_DEPTH - 1);
  localparam logic [CountBits-1:0] CountMax = '1;

  logic [ThrBits-1:0]    accel_thr_q, gyro_thr_q;
  logic [SampleBits-1:0] smp_q [NumAxes];
  logic [SqBits-1:0]     prod_q, acc_accel_q, acc_gyro_q;
  logic                  prod_vld_q, prod_gyro_q;
  logic [CountBits-1:0]  count_q;
  logic                  shot_q;
  logic [SlotW-1:0]      wr_slot_q, rd_slot_q, rd_slot_d;
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [RingBits-1:0]   ring_mem [RING_DEPTH];
  logic [RingBits-1:0]   rd_data_q;
  logic                  rd_vld_q;
  logic [RingBits-1:0]   snap;
  logic                  out_valid_q, out_kind_q, out_seen_q, out_last_q;
  logic [CountBits-1:0]  out_count_q;
  logic [RingBits-1:0]   out_snap_q;
  logic                  out_free;
  logic                  shot_now;
  logic signed [SampleBits-1:0] mul_op;
  logic signed [SqBits-1:0]     mul_sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_thr_q <= ThrBits'(389000000);
      gyro_thr_q  <= ThrBits'(202500);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_THR: accel_thr_q <= cfg_data_i;
        CFG_GYRO_THR:  gyro_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < NumAxes; i++) begin
        smp_q[i] <= s_data_i[i*SampleBits +: SampleBits];
      end
    end
  end

  assign mul_op = smp_q[cmd_i.mul_sel];
  assign mul_sq = mul_op * mul_op;

  always_ff @(posedge clk_i) begin
    prod_q      <= mul_sq;
    prod_gyro_q <= (cmd_i.mul_sel >= AxisSelBits'(GyroFirst));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      acc_accel_q <= '0;
      acc_gyro_q  <= '0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
      if (cmd_i.load) begin
        acc_accel_q <= '0;
        acc_gyro_q  <= '0;
      end else if (prod_vld_q) begin
        if (prod_gyro_q) begin
          acc_gyro_q <= acc_gyro_q + prod_q;
        end else begin
          acc_accel_q <= acc_accel_q + prod_q;
        end
      end
    end
  end

  assign shot_now = (acc_gyro_q > gyro_thr_q) && (acc_accel_q > accel_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      shot_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (s_clear_i) begin
        count_q <= '0;
      end
    end else if (cmd_i.judge) begin
      shot_q <= shot_now;
      if (shot_now && count_q != CountMax) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // ring: written on load, read one slot ahead so rd_data_q tracks rd_slot_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q  <= '0;
      ring_vld_q <= '0;
    end else if (cmd_i.load) begin
      ring_vld_q[wr_slot_q] <= 1'b1;
      wr_slot_q <= (wr_slot_q == LastSlot) ? '0 : wr_slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_mem[wr_slot_q] <= s_data_i[InDataBits-1 -: RingBits];
    end
    rd_data_q <= ring_mem[rd_slot_d];
  end

  always_comb begin
    rd_slot_d = rd_slot_q;
    if (cmd_i.out_status) begin
      rd_slot_d = wr_slot_q;
    end else if (cmd_i.out_snap) begin
      rd_slot_d = (rd_slot_q == LastSlot) ? '0 : rd_slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_slot_q <= rd_slot_d;
      rd_vld_q  <= ring_vld_q[rd_slot_d];
    end
  end

  assign snap = rd_vld_q ? rd_data_q : '0;

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_status || cmd_i.out_snap) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_status) begin
      out_kind_q  <= KIND_STATUS;
      out_count_q <= count_q;
      out_seen_q  <= shot_q;
      out_snap_q  <= '0;
      out_last_q  <= !shot_q;
    end else if (cmd_i.out_snap) begin
      out_kind_q  <= KIND_SNAP;
      out_count_q <= count_q;
      out_seen_q  <= 1'b1;
      out_snap_q  <= snap;
      out_last_q  <= cmd_i.snap_last;
    end
  end

  assign sts_o.out_free = out_free;
  assign sts_o.shot     = shot_q;

  assign m_valid_o = out_valid_q;
  assign m_kind_o  = out_kind_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {(OutDataBits - OutFieldBits)'(0), out_snap_q, out_seen_q, out_count_q};

endmodule
`default_nettype wire
